// ----- design/lcabl_pkg.sv -----
// Package for the binary-lifting common ancestor block.
// Holds field widths, codes, controller states, datapath operations and status.
// No dependencies.
package lcabl_pkg;

    localparam int NODE_W    = 12;
    localparam int DEPTH_W   = 12;
    localparam int COUNT_W   = 13;
    localparam int MAX_NODES = 4096;
    localparam int LIFT_W    = 17;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BINIT,
        ST_BRD1,
        ST_BRD2,
        ST_BWR,
        ST_QDB,
        ST_QSW,
        ST_LCHK,
        ST_LJMP,
        ST_LDEP,
        ST_EQ,
        ST_P2Y,
        ST_P2C,
        ST_P2F,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_QNULL,
        OP_QSTART,
        OP_BINIT,
        OP_BRD1,
        OP_BRD2,
        OP_BWR,
        OP_QDB,
        OP_QSW,
        OP_LCHK,
        OP_LJMP,
        OP_LDEP,
        OP_EQ,
        OP_P2Y,
        OP_P2C,
        OP_P2F,
        OP_PUSH
    } dp_op_t;

    typedef struct packed {
        logic lift_go;
        logic lvl_zero;
        logic x_eq_y;
        logic build_empty;
        logic build_last;
    } dp_status_t;

endpackage

// ----- design/lcabl_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the jump table and the depth table. No dependencies.
module lcabl_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/lcabl_dp.sv -----
// Datapath: jump table and depth table memories, node and depth registers,
// level and build counters, the result and output registers.
// Depends on lcabl_pkg and lcabl_ram; driven by operations from lcabl_ctrl.
module lcabl_dp #(
    parameter int LEVELS = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lcabl_pkg::COUNT_W-1:0]    cfg_wdata,
    input  logic [lcabl_pkg::NODE_W-1:0]     in_a,
    input  logic [lcabl_pkg::NODE_W-1:0]     in_b,
    input  logic [lcabl_pkg::DEPTH_W-1:0]    in_depth,
    input  lcabl_pkg::dp_op_t                op,
    output lcabl_pkg::dp_status_t            status,
    output logic [lcabl_pkg::NODE_W-1:0]     out_anc,
    output logic                             out_ok
);

    import lcabl_pkg::*;

    localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int JT_DEPTH = LEVELS * MAX_NODES;
    localparam int JA_W     = $clog2(JT_DEPTH);
    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);

    logic [COUNT_W-1:0] node_count_reg, node_count_next;
    logic [LVL_W-1:0]   lvl_reg, lvl_next;
    logic [LVL_W-1:0]   bj_reg, bj_next;
    logic [NODE_W-1:0]  bi_reg, bi_next;
    logic [NODE_W-1:0]  x_reg, x_next;
    logic [NODE_W-1:0]  y_reg, y_next;
    logic [NODE_W-1:0]  px_reg, px_next;
    logic [DEPTH_W-1:0] dx_reg, dx_next;
    logic [DEPTH_W-1:0] dy_reg, dy_next;
    logic [NODE_W-1:0]  ans_reg, ans_next;
    logic               ans_ok_reg, ans_ok_next;
    logic [NODE_W-1:0]  out_anc_reg, out_anc_next;
    logic               out_ok_reg, out_ok_next;

    logic               jt_we;
    logic [JA_W-1:0]    jt_waddr;
    logic [NODE_W-1:0]  jt_wdata;
    logic [JA_W-1:0]    jt_raddr;
    logic [NODE_W-1:0]  jt_q;
    logic               dt_we;
    logic [NODE_W-1:0]  dt_waddr;
    logic [DEPTH_W-1:0] dt_wdata;
    logic [NODE_W-1:0]  dt_raddr;
    logic [DEPTH_W-1:0] dt_q;

    logic [COUNT_W-1:0] lim;
    logic               bi_last;
    logic               bj_last;
    logic [DEPTH_W:0]   diff;
    logic [LIFT_W-1:0]  step;
    logic [LVL_W-1:0]   lvl_dec;
    logic [NODE_W-1:0]  p2_x;

    function automatic logic [JA_W-1:0] jaddr(input logic [LVL_W-1:0] lvl,
                                              input logic [NODE_W-1:0] node);
        return JA_W'({lvl, node});
    endfunction

    lcabl_ram #(
        .WIDTH (NODE_W),
        .DEPTH (JT_DEPTH)
    ) u_jump_ram (
        .clk   (clk),
        .we    (jt_we),
        .waddr (jt_waddr),
        .wdata (jt_wdata),
        .raddr (jt_raddr),
        .rdata (jt_q)
    );

    lcabl_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (MAX_NODES)
    ) u_depth_ram (
        .clk   (clk),
        .we    (dt_we),
        .waddr (dt_waddr),
        .wdata (dt_wdata),
        .raddr (dt_raddr),
        .rdata (dt_q)
    );

    assign lim     = (node_count_reg > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES)
                                                            : node_count_reg;
    assign bi_last = ({1'b0, bi_reg} == (lim - COUNT_W'(1)));
    assign bj_last = (bj_reg == LVL_TOP);
    assign diff    = {1'b0, dy_reg} - {1'b0, dx_reg};
    assign step    = LIFT_W'(1) << lvl_reg;
    assign lvl_dec = (lvl_reg == '0) ? '0 : lvl_reg - LVL_W'(1);
    assign p2_x    = (px_reg != jt_q) ? px_reg : x_reg;

    assign status.lift_go     = !diff[DEPTH_W] && (LIFT_W'(diff[DEPTH_W-1:0]) >= step);
    assign status.lvl_zero    = (lvl_reg == '0);
    assign status.x_eq_y      = (x_reg == y_reg);
    assign status.build_empty = (LEVELS == 1) || (lim == '0);
    assign status.build_last  = bi_last && bj_last;

    always_comb
    begin
        node_count_next = cfg_we ? cfg_wdata : node_count_reg;
        lvl_next     = lvl_reg;
        bj_next      = bj_reg;
        bi_next      = bi_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        px_next      = px_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        ans_next     = ans_reg;
        ans_ok_next  = ans_ok_reg;
        out_anc_next = out_anc_reg;
        out_ok_next  = out_ok_reg;
        jt_we        = 1'b0;
        jt_waddr     = '0;
        jt_wdata     = '0;
        jt_raddr     = '0;
        dt_we        = 1'b0;
        dt_waddr     = '0;
        dt_wdata     = '0;
        dt_raddr     = '0;
        unique case (op)
            OP_LOAD:
            begin
                jt_we    = 1'b1;
                jt_waddr = jaddr('0, in_a);
                jt_wdata = in_b;
                dt_we    = 1'b1;
                dt_waddr = in_a;
                dt_wdata = in_depth;
            end
            OP_QNULL:
            begin
                ans_next    = '0;
                ans_ok_next = 1'b0;
            end
            OP_QSTART:
            begin
                x_next   = in_a;
                y_next   = in_b;
                dt_raddr = in_a;
            end
            OP_BINIT:
            begin
                bj_next = LVL_W'(1);
                bi_next = '0;
            end
            OP_BRD1:
            begin
                jt_raddr = jaddr(bj_reg - LVL_W'(1), bi_reg);
            end
            OP_BRD2:
            begin
                jt_raddr = jaddr(bj_reg - LVL_W'(1), jt_q);
            end
            OP_BWR:
            begin
                jt_we    = 1'b1;
                jt_waddr = jaddr(bj_reg, bi_reg);
                jt_wdata = jt_q;
                if (bi_last)
                begin
                    bi_next = '0;
                    bj_next = bj_reg + LVL_W'(1);
                end
                else
                begin
                    bi_next = bi_reg + NODE_W'(1);
                end
            end
            OP_QDB:
            begin
                dx_next  = dt_q;
                dt_raddr = y_reg;
            end
            OP_QSW:
            begin
                if (dx_reg > dt_q)
                begin
                    x_next  = y_reg;
                    y_next  = x_reg;
                    dx_next = dt_q;
                    dy_next = dx_reg;
                end
                else
                begin
                    dy_next = dt_q;
                end
                lvl_next = LVL_TOP;
            end
            OP_LCHK:
            begin
                jt_raddr = jaddr(lvl_reg, y_reg);
                if (!status.lift_go)
                begin
                    lvl_next = lvl_dec;
                end
            end
            OP_LJMP:
            begin
                y_next   = jt_q;
                dt_raddr = jt_q;
            end
            OP_LDEP:
            begin
                dy_next  = dt_q;
                lvl_next = lvl_dec;
            end
            OP_EQ:
            begin
                ans_next    = x_reg;
                ans_ok_next = 1'b1;
                lvl_next    = LVL_TOP;
                jt_raddr    = jaddr(LVL_TOP, x_reg);
            end
            OP_P2Y:
            begin
                px_next  = jt_q;
                jt_raddr = jaddr(lvl_reg, y_reg);
            end
            OP_P2C:
            begin
                if (px_reg != jt_q)
                begin
                    x_next = px_reg;
                    y_next = jt_q;
                end
                jt_raddr = jaddr(lvl_dec, p2_x);
                lvl_next = lvl_dec;
            end
            OP_P2F:
            begin
                ans_next = jt_q;
            end
            OP_PUSH:
            begin
                out_anc_next = ans_reg;
                out_ok_next  = ans_ok_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= COUNT_RESET;
            lvl_reg        <= '0;
            bj_reg         <= '0;
            bi_reg         <= '0;
        end
        else
        begin
            node_count_reg <= node_count_next;
            lvl_reg        <= lvl_next;
            bj_reg         <= bj_next;
            bi_reg         <= bi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        px_reg      <= px_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        ans_reg     <= ans_next;
        ans_ok_reg  <= ans_ok_next;
        out_anc_reg <= out_anc_next;
        out_ok_reg  <= out_ok_next;
    end

    assign out_anc = out_anc_reg;
    assign out_ok  = out_ok_reg;

endmodule

// ----- design/lcabl_ctrl.sv -----
// Controller state machine: sequences loads, the jump table build and queries,
// and owns the built flag and the output valid flag.
// Depends on lcabl_pkg; commands lcabl_dp through one operation per cycle.
module lcabl_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_valid,
    input  logic                  s_action,
    input  logic                  s_last,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lcabl_pkg::dp_op_t     op,
    input  lcabl_pkg::dp_status_t status
);

    import lcabl_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        built_reg, built_next;
    logic        m_valid_reg, m_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        built_next   = built_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    if (s_action == ACT_LOAD)
                    begin
                        built_next = 1'b0;
                        if (s_last)
                        begin
                            state_next = ST_BINIT;
                        end
                    end
                    else
                    begin
                        state_next = built_reg ? ST_QDB : ST_DONE;
                    end
                end
            end
            ST_BINIT:
            begin
                if (status.build_empty)
                begin
                    built_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_BRD1;
                end
            end
            ST_BRD1:
            begin
                state_next = ST_BRD2;
            end
            ST_BRD2:
            begin
                state_next = ST_BWR;
            end
            ST_BWR:
            begin
                if (status.build_last)
                begin
                    built_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_BRD1;
                end
            end
            ST_QDB:
            begin
                state_next = ST_QSW;
            end
            ST_QSW:
            begin
                state_next = ST_LCHK;
            end
            ST_LCHK:
            begin
                if (status.lift_go)
                begin
                    state_next = ST_LJMP;
                end
                else if (status.lvl_zero)
                begin
                    state_next = ST_EQ;
                end
            end
            ST_LJMP:
            begin
                state_next = ST_LDEP;
            end
            ST_LDEP:
            begin
                state_next = status.lvl_zero ? ST_EQ : ST_LCHK;
            end
            ST_EQ:
            begin
                state_next = status.x_eq_y ? ST_DONE : ST_P2Y;
            end
            ST_P2Y:
            begin
                state_next = ST_P2C;
            end
            ST_P2C:
            begin
                state_next = status.lvl_zero ? ST_P2F : ST_P2Y;
            end
            ST_P2F:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_ready)
                begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_ready = (state_reg == ST_IDLE);
        op      = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    if (s_action == ACT_LOAD)
                    begin
                        op = OP_LOAD;
                    end
                    else
                    begin
                        op = built_reg ? OP_QSTART : OP_QNULL;
                    end
                end
            end
            ST_BINIT: op = OP_BINIT;
            ST_BRD1:  op = OP_BRD1;
            ST_BRD2:  op = OP_BRD2;
            ST_BWR:   op = OP_BWR;
            ST_QDB:   op = OP_QDB;
            ST_QSW:   op = OP_QSW;
            ST_LCHK:  op = OP_LCHK;
            ST_LJMP:  op = OP_LJMP;
            ST_LDEP:  op = OP_LDEP;
            ST_EQ:    op = OP_EQ;
            ST_P2Y:   op = OP_P2Y;
            ST_P2C:   op = OP_P2C;
            ST_P2F:   op = OP_P2F;
            ST_DONE:
            begin
                if (!m_valid_reg || m_ready)
                begin
                    op = OP_PUSH;
                end
            end
            default:  op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            built_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            built_reg   <= built_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    a_load_clears_built: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && s_valid && s_action == ACT_LOAD) |=> !built_reg)
        else $error("load did not clear the built flag");

    a_build_end_sets_built: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BWR && status.build_last) |=> (built_reg && state_reg == ST_IDLE))
        else $error("table build did not finish cleanly");

    a_done_waits_for_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && m_valid_reg && !m_ready) |=> (state_reg == ST_DONE))
        else $error("result left while the output item was still held");

    a_query_needs_built: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_QDB) |-> built_reg)
        else $error("query walk started without a built table");

endmodule

// ----- design/lca_binary_lifting.sv -----
// Top level of the binary-lifting lowest common ancestor block.
// Depends on lcabl_pkg, lcabl_ctrl and lcabl_dp (which holds two lcabl_ram).
//
// Channel   Direction  Contents
// s_axis    in         tdata: node_a, node_b, node_depth; tuser: action; tlast: last
// m_axis    out        tdata: ancestor; tuser: ready_res
// cfg       in         node_count, written when cfg_we is high
//
// A load marked last then builds the table for min(node_count, 4096) nodes and
// levels 1 to LEVELS - 1, with two reads through the single read port of the jump
// table memory and one write per entry. A query on a table not built returns
// ready_res low; otherwise it makes two dependent memory reads per lifting level.
// After reset no table is built. A finished result waits in the output register
// while the next item is accepted; a further query holds until that slot is free.
module lca_binary_lifting #(
    parameter int LEVELS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // node_a [11:0], node_b [23:12], node_depth [35:24], zeros above.
    input  logic [lcabl_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // action.
    input  logic                               s_axis_tuser,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // ancestor [11:0], zeros above.
    output logic [lcabl_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // ready_res.
    output logic                               m_axis_tuser,
    input  logic                               cfg_we,
    input  logic [lcabl_pkg::COUNT_W-1:0]      cfg_wdata
);

    import lcabl_pkg::*;

    dp_op_t             op;
    dp_status_t         status;
    logic [NODE_W-1:0]  out_anc;
    logic               out_ok;

    lcabl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_axis_tvalid),
        .s_action (s_axis_tuser),
        .s_last   (s_axis_tlast),
        .s_ready  (s_axis_tready),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .op       (op),
        .status   (status)
    );

    lcabl_dp #(
        .LEVELS (LEVELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_a      (s_axis_tdata[NODE_W-1:0]),
        .in_b      (s_axis_tdata[2*NODE_W-1:NODE_W]),
        .in_depth  (s_axis_tdata[2*NODE_W+DEPTH_W-1:2*NODE_W]),
        .op        (op),
        .status    (status),
        .out_anc   (out_anc),
        .out_ok    (out_ok)
    );

    assign m_axis_tdata = M_TDATA_W'(out_anc);
    assign m_axis_tuser = out_ok;

endmodule
